### hdl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types, constants and helpers of the sample despike filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  localparam int DATA_W       = 32;
  localparam int SLOPE_W      = 31;
  localparam int RATE_CFG_W   = 6;
  localparam int CNT_W        = 6;
  localparam int HIST_LEN     = 3;
  localparam int MAX_RATE_DEF = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int TDATA_IN_W   = 40;
  localparam int TDATA_OUT_W  = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_SLOPE = 2'd1;

  localparam logic [RATE_CFG_W-1:0] RATE_RESET  = 6'd1;
  localparam logic [SLOPE_W-1:0]    SLOPE_RESET = 31'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]      CNT_MAX     = 6'd63;

  typedef struct packed {
    logic                     m;
    logic signed [DATA_W-1:0] v;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R1_RD0,
    ST_R1_RD1,
    ST_R1_EVAL,
    ST_M_RD_PREV,
    ST_M_RD_CUR,
    ST_M_EVAL,
    ST_S_RD,
    ST_S_EVAL,
    ST_E_RD,
    ST_E_LD
  } state_t;

  function automatic logic signed [DATA_W:0] diff33(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
    diff33 = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  endfunction

  function automatic logic [DATA_W-1:0] absdiff(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    logic [DATA_W:0] n;
    d = diff33(a, b);
    n = ~d + 1'b1;
    absdiff = d[DATA_W] ? n[DATA_W-1:0] : d[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/sample_despike_filter_unit.sv
// ----------------------------------------------------------------------------
// sample_despike_filter_unit
// Despikes a stream of fixed-point samples, one record late.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while no record is being processed. A sample
// that closes a record (after the first one) starts the scan of the held
// record: at a rate above one, each record position is checked for a jump from
// the sample before it, a jump opens a search over the samples that follow it,
// and then the held record is emitted one sample at a time as the output takes
// it. The single read port of the window memory delivers one window sample at
// a time during the scan. The window memory needs no clearing after reset. The
// output register lets the next input be accepted while the last result waits
// downstream.
`default_nettype none

module sample_despike_filter_unit #(
  parameter int MAX_RATE = sdf_pkg::MAX_RATE_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // cfg
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [sdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sdf_pkg::SLOPE_W-1:0]          cfg_data,
  // in: [31:0] sample_value, [32] sample_missing, [39:33] zero
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  input  wire logic [sdf_pkg::TDATA_IN_W-1:0]       in_tdata,
  // out: [31:0] out_value, [32] out_missing, [38:33] spike_count, [39] zero
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  output      logic [sdf_pkg::TDATA_OUT_W-1:0]      out_tdata,
  output      logic                                 out_tlast
);

  localparam int RATE_W = $clog2(MAX_RATE + 1);
  localparam int IDX_W  = (MAX_RATE > 1) ? $clog2(MAX_RATE) : 1;
  localparam int MEM_AW = IDX_W + 1;
  localparam int MEM_D  = 2 ** MEM_AW;
  localparam int WIN_W  = $clog2(2 * MAX_RATE + 4);
  localparam int DW     = sdf_pkg::DATA_W;
  localparam int SW     = sdf_pkg::SLOPE_W;
  localparam int CW     = sdf_pkg::CNT_W;
  localparam logic [WIN_W-1:0] HL = WIN_W'(sdf_pkg::HIST_LEN);

  function automatic logic [RATE_W-1:0] eff_rate(input logic [sdf_pkg::RATE_CFG_W-1:0] raw);
    if (raw == '0) begin
      eff_rate = RATE_W'(1);
    end else if (32'(raw) > 32'(MAX_RATE)) begin
      eff_rate = RATE_W'(MAX_RATE);
    end else begin
      eff_rate = RATE_W'(raw);
    end
  endfunction

  // registers
  sdf_pkg::state_t                   state_r, state_nxt;
  logic [sdf_pkg::RATE_CFG_W-1:0]    rate_r, rate_nxt;
  logic [SW-1:0]                     slope_r, slope_nxt;
  logic [RATE_W-1:0]                 fill_r, fill_nxt;
  logic                              have_r, have_nxt;
  logic                              bank_r, bank_nxt;
  sdf_pkg::sample_t                  hist_r [sdf_pkg::HIST_LEN];
  sdf_pkg::sample_t                  hist_nxt [sdf_pkg::HIST_LEN];
  logic [WIN_W-1:0]                  i_r, i_nxt;
  logic [WIN_W-1:0]                  ex_r, ex_nxt;
  logic [WIN_W-1:0]                  first_r, first_nxt;
  logic                              found_r, found_nxt;
  logic [1:0]                        cons_r, cons_nxt;
  logic signed [DW-1:0]              ref_r, ref_nxt;
  sdf_pkg::sample_t                  prev_r, prev_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [MAX_RATE-1:0]               rem_r, rem_nxt;
  logic [RATE_W-1:0]                 k_r, k_nxt;
  logic                              selh_r;
  sdf_pkg::sample_t                  hpick_r;
  logic                              ov_r, ov_nxt;
  logic [DW-1:0]                     oval_r, oval_nxt;
  logic                              omis_r, omis_nxt;
  logic                              olast_r, olast_nxt;
  logic [CW-1:0]                     ocnt_r, ocnt_nxt;

  // window memory
  sdf_pkg::sample_t                  mem [MEM_D];
  sdf_pkg::sample_t                  mem_q;
  logic                              we, re;
  logic [MEM_AW-1:0]                 waddr, raddr;
  sdf_pkg::sample_t                  wdata;

  logic [RATE_W-1:0]                 r_eff;
  logic [WIN_W-1:0]                  r_w, rd_j, off, win_end, rec_end;
  sdf_pkg::sample_t                  fetched, in_s, c;
  logic                              accept;
  logic signed [DW:0]                d1, d2;
  logic                              close, jump;
  logic [1:0]                        cons_n;
  logic                              found_n;
  logic [WIN_W-1:0]                  first_n;
  logic [WIN_W-1:0]                  pw;
  logic                              k_last;

  assign r_eff   = eff_rate(rate_r);
  assign r_w     = WIN_W'(r_eff);
  assign rec_end = r_w + HL;
  assign win_end = (r_w << 1) + WIN_W'(2);
  assign fetched = selh_r ? hpick_r : mem_q;
  assign in_s.v  = in_tdata[DW-1:0];
  assign in_s.m  = in_tdata[DW];
  assign accept  = in_tvalid && in_tready;
  assign k_last  = (k_r == r_eff - RATE_W'(1));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == sdf_pkg::ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, ocnt_r, omis_r, oval_r};

  // read address mapping of window position rd_j
  always_comb begin
    off = rd_j - HL;
    if (off < r_w) begin
      raddr = {bank_r, off[IDX_W-1:0]};
    end else begin
      raddr = {~bank_r, IDX_W'(off - r_w)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      selh_r  <= (rd_j < HL);
      hpick_r <= hist_r[rd_j[1:0] == 2'd3 ? 2'd2 : rd_j[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdf_pkg::ST_IDLE;
      rate_r  <= sdf_pkg::RATE_RESET;
      slope_r <= sdf_pkg::SLOPE_RESET;
      fill_r  <= '0;
      have_r  <= 1'b0;
      bank_r  <= 1'b0;
      ov_r    <= 1'b0;
      for (int h = 0; h < sdf_pkg::HIST_LEN; h++) begin
        hist_r[h] <= '{m: 1'b1, v: '0};
      end
    end else begin
      state_r <= state_nxt;
      rate_r  <= rate_nxt;
      slope_r <= slope_nxt;
      fill_r  <= fill_nxt;
      have_r  <= have_nxt;
      bank_r  <= bank_nxt;
      ov_r    <= ov_nxt;
      hist_r  <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    ex_r    <= ex_nxt;
    first_r <= first_nxt;
    found_r <= found_nxt;
    cons_r  <= cons_nxt;
    ref_r   <= ref_nxt;
    prev_r  <= prev_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    k_r     <= k_nxt;
    oval_r  <= oval_nxt;
    omis_r  <= omis_nxt;
    olast_r <= olast_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rate_nxt  = rate_r;
    slope_nxt = slope_r;
    fill_nxt  = fill_r;
    have_nxt  = have_r;
    bank_nxt  = bank_r;
    hist_nxt  = hist_r;
    i_nxt     = i_r;
    ex_nxt    = ex_r;
    first_nxt = first_r;
    found_nxt = found_r;
    cons_nxt  = cons_r;
    ref_nxt   = ref_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    oval_nxt  = oval_r;
    omis_nxt  = omis_r;
    olast_nxt = olast_r;
    ocnt_nxt  = ocnt_r;
    ov_nxt    = ov_r && !out_tready;
    we        = 1'b0;
    waddr     = {~bank_r, fill_r[IDX_W-1:0]};
    wdata     = in_s;
    re        = 1'b0;
    rd_j      = HL;
    c         = fetched;
    d1        = '0;
    d2        = '0;
    close     = 1'b0;
    jump      = 1'b0;
    cons_n    = '0;
    found_n   = found_r;
    first_n   = first_r;
    pw        = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdf_pkg::CFG_SAMPLE_RATE: begin
          rate_nxt = cfg_data[sdf_pkg::RATE_CFG_W-1:0];
          if (eff_rate(cfg_data[sdf_pkg::RATE_CFG_W-1:0]) != r_eff) begin
            fill_nxt = '0;
            have_nxt = 1'b0;
          end
        end
        sdf_pkg::CFG_SPIKE_SLOPE: slope_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      sdf_pkg::ST_IDLE: begin
        if (accept) begin
          we = 1'b1;
          if (fill_r + RATE_W'(1) == r_eff) begin
            fill_nxt = '0;
            cnt_nxt  = '0;
            rem_nxt  = '0;
            if (have_r) begin
              if (r_eff == RATE_W'(1)) begin
                state_nxt = sdf_pkg::ST_R1_RD0;
              end else begin
                i_nxt     = HL;
                state_nxt = sdf_pkg::ST_M_RD_PREV;
              end
            end else begin
              bank_nxt = ~bank_r;
              have_nxt = 1'b1;
            end
          end else begin
            fill_nxt = fill_r + RATE_W'(1);
          end
        end
      end

      sdf_pkg::ST_R1_RD0: begin
        re        = 1'b1;
        rd_j      = HL;
        state_nxt = sdf_pkg::ST_R1_RD1;
      end

      sdf_pkg::ST_R1_RD1: begin
        re        = 1'b1;
        rd_j      = HL + WIN_W'(1);
        prev_nxt  = fetched;
        state_nxt = sdf_pkg::ST_R1_EVAL;
      end

      sdf_pkg::ST_R1_EVAL: begin
        d1 = sdf_pkg::diff33(hist_r[2].v, prev_r.v);
        d2 = sdf_pkg::diff33(prev_r.v, fetched.v);
        if (!hist_r[2].m && !prev_r.m && !fetched.m &&
            ((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)) &&
            sdf_pkg::absdiff(hist_r[2].v, prev_r.v) > {1'b0, slope_r} &&
            sdf_pkg::absdiff(prev_r.v, fetched.v) > {1'b0, slope_r}) begin
          rem_nxt[0] = 1'b1;
          cnt_nxt    = CW'(1);
        end
        k_nxt     = '0;
        state_nxt = sdf_pkg::ST_E_RD;
      end

      sdf_pkg::ST_M_RD_PREV: begin
        re        = 1'b1;
        rd_j      = i_r - WIN_W'(1);
        state_nxt = sdf_pkg::ST_M_RD_CUR;
      end

      sdf_pkg::ST_M_RD_CUR: begin
        re        = 1'b1;
        rd_j      = i_r;
        prev_nxt  = fetched;
        state_nxt = sdf_pkg::ST_M_EVAL;
      end

      sdf_pkg::ST_M_EVAL: begin
        jump = !prev_r.m && !fetched.m &&
               (sdf_pkg::absdiff(prev_r.v, fetched.v) > {1'b0, slope_r});
        if (jump) begin
          ref_nxt   = prev_r.v;
          ex_nxt    = i_r;
          cons_nxt  = '0;
          found_nxt = 1'b0;
          first_nxt = i_r;
          state_nxt = sdf_pkg::ST_S_RD;
        end else begin
          i_nxt = i_r + WIN_W'(1);
          if (i_r + WIN_W'(1) < rec_end) begin
            state_nxt = sdf_pkg::ST_M_RD_PREV;
          end else begin
            k_nxt     = '0;
            state_nxt = sdf_pkg::ST_E_RD;
          end
        end
      end

      sdf_pkg::ST_S_RD: begin
        re        = 1'b1;
        rd_j      = ex_r + WIN_W'(1);
        ex_nxt    = ex_r + WIN_W'(1);
        state_nxt = sdf_pkg::ST_S_EVAL;
      end

      sdf_pkg::ST_S_EVAL: begin
        close = !fetched.m && (sdf_pkg::absdiff(ref_r, fetched.v) < {1'b0, slope_r});
        if (close) begin
          cons_n = cons_r + 2'd1;
          if (!found_r) begin
            first_n = ex_r;
            found_n = 1'b1;
          end
        end
        cons_nxt  = cons_n;
        found_nxt = found_n;
        first_nxt = first_n;
        if (cons_n != 2'd3 && ex_r < win_end) begin
          state_nxt = sdf_pkg::ST_S_RD;
        end else if (cons_n == 2'd3) begin
          for (int p = 0; p < MAX_RATE; p++) begin
            pw = WIN_W'(p) + HL;
            if (pw >= i_r && pw < first_n) begin
              rem_nxt[p] = 1'b1;
            end
          end
          if (cnt_r != sdf_pkg::CNT_MAX) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          i_nxt = ex_r;
          if (ex_r < rec_end) begin
            state_nxt = sdf_pkg::ST_M_RD_PREV;
          end else begin
            k_nxt     = '0;
            state_nxt = sdf_pkg::ST_E_RD;
          end
        end else begin
          i_nxt = i_r + WIN_W'(1);
          if (i_r + WIN_W'(1) < rec_end) begin
            state_nxt = sdf_pkg::ST_M_RD_PREV;
          end else begin
            k_nxt     = '0;
            state_nxt = sdf_pkg::ST_E_RD;
          end
        end
      end

      sdf_pkg::ST_E_RD: begin
        re        = 1'b1;
        rd_j      = HL + WIN_W'(k_r);
        state_nxt = sdf_pkg::ST_E_LD;
      end

      sdf_pkg::ST_E_LD: begin
        c.v = fetched.v;
        c.m = fetched.m || rem_r[k_r[IDX_W-1:0]];
        if (!ov_r || out_tready) begin
          ov_nxt      = 1'b1;
          oval_nxt    = c.m ? '0 : c.v;
          omis_nxt    = c.m;
          olast_nxt   = k_last;
          ocnt_nxt    = k_last ? cnt_r : '0;
          hist_nxt[0] = hist_r[1];
          hist_nxt[1] = hist_r[2];
          hist_nxt[2] = c;
          k_nxt       = k_r + RATE_W'(1);
          if (k_last) begin
            bank_nxt  = ~bank_r;
            have_nxt  = 1'b1;
            state_nxt = sdf_pkg::ST_IDLE;
          end else begin
            state_nxt = sdf_pkg::ST_E_RD;
          end
        end
      end

      default: state_nxt = sdf_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
